FILE: hw/rtl/rgbw_pkg.sv
// Shared types, mode codes and coefficient tables for the RGB to RGBW converter.
// No dependencies; every other RTL file in hw/rtl refers to it by scoped names.
`default_nettype none

package rgbw_pkg;

    // White extraction modes
    localparam logic [3:0] MODE_OFF      = 4'd0;
    localparam logic [3:0] MODE_SUBMIN   = 4'd1;
    localparam logic [3:0] MODE_WARM     = 4'd2;
    localparam logic [3:0] MODE_COOL     = 4'd3;
    localparam logic [3:0] MODE_AUTO     = 4'd4;
    localparam logic [3:0] MODE_AUTOMAX  = 4'd5;
    localparam logic [3:0] MODE_AUTOACC  = 4'd6;
    localparam logic [3:0] MODE_COLD     = 4'd7;
    localparam logic [3:0] MODE_NEUTRAL  = 4'd8;

    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned COEF_W    = 18;   // widest forward weight
    localparam int unsigned INV_W     = 20;   // widest inverse weight
    localparam int unsigned PROD_W    = 8 + COEF_W;
    localparam int unsigned IPROD_W   = 8 + INV_W;
    localparam int unsigned SCL_W     = PROD_W - FRAC_BITS;   // per-channel scaled value
    localparam int unsigned SUB_W     = IPROD_W - FRAC_BITS;  // amount taken off a channel

    // Forward weights and inverses, 16 fraction bits, lane 0 = red
    localparam logic [2:0][COEF_W-1:0] WARM_W = {18'd152895, 18'd29753, 18'd17957};
    localparam logic [2:0][INV_W-1:0]  WARM_I = {20'd28091, 20'd144352, 20'd239182};
    localparam logic [2:0][COEF_W-1:0] COOL_W = {18'd7471, 18'd38470, 18'd19595};
    localparam logic [2:0][INV_W-1:0]  COOL_I = {20'd574877, 20'd111646, 20'd219184};
    // Integer scale constants, divided by 255 with rounding
    localparam logic [2:0][COEF_W-1:0] COLD_K = {18'h000A0, 18'h000A0, 18'h000A0};
    localparam logic [2:0][COEF_W-1:0] NEUT_K = {18'h00070, 18'h000B0, 18'h000B0};

    typedef logic [2:0][7:0]        chan3_t;
    typedef logic [2:0][SCL_W-1:0]  scl3_t;
    typedef logic [2:0][SUB_W-1:0]  sub3_t;

    // Input and result words
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] white_out;
    } pixel_out_t;

    // Scale stage to white stage
    typedef struct packed {
        logic       valid;
        logic [3:0] mode;
        chan3_t     ch;
        scl3_t      scl;
    } scaled_t;

    // White stage to extract stage
    typedef struct packed {
        logic       valid;
        logic [3:0] mode;
        chan3_t     ch;
        scl3_t      scl;
        logic [7:0] white;
    } white_t;

    // Forward multiplier coefficient for one lane
    function automatic logic [COEF_W-1:0] fwd_coef(input logic [3:0] mode,
                                                   input logic [1:0] lane);
        logic [COEF_W-1:0] c;
        begin
            unique case (mode)
                MODE_WARM:    c = WARM_W[lane];
                MODE_COOL:    c = COOL_W[lane];
                MODE_COLD:    c = COLD_K[lane];
                MODE_NEUTRAL: c = NEUT_K[lane];
                default:      c = '0;
            endcase
            return c;
        end
    endfunction

    // Inverse coefficient for one lane
    function automatic logic [INV_W-1:0] inv_coef(input logic [3:0] mode,
                                                  input logic [1:0] lane);
        logic [INV_W-1:0] c;
        begin
            unique case (mode)
                MODE_WARM: c = WARM_I[lane];
                MODE_COOL: c = COOL_I[lane];
                default:   c = '0;
            endcase
            return c;
        end
    endfunction

    // Rounded divide by 255 of a 16-bit value, saturating at 255
    function automatic logic [7:0] rdiv255(input logic [15:0] x);
        logic [16:0] y;
        logic [16:0] q;
        begin
            y = {1'b0, x} + 17'd127;
            q = (y + (y >> 8) + 17'd1) >> 8;
            return (q > 17'd255) ? 8'hFF : q[7:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rgb_to_rgbw_converter.sv
// Top level of the RGB to RGBW converter: mode register and five-stage pipeline.
// Depends on rgbw_pkg, rgbw_scale, rgbw_white and rgbw_extract.
//
//  channel   signals                          word           flow control
//  -------   -------------------------------  -------------  --------------------------
//  pixel     start, busy, pixel               pixel_in_t     taken when start && !busy
//  result    done, rgbw                       pixel_out_t    one-cycle strobe, no stall
//  config    cfg_valid, cfg_ready, cfg_data   4-bit mode     written when valid && ready
//
// One pixel per clock; busy is never raised. The stage registers are, in order:
// multiply, scale, white select, inverse multiply, subtract.
// The mode is sampled with each pixel and travels with it down the pipeline.
// Reset clears the valid bits and sets the mode to off (pass through, white 0).
`default_nettype none

module rgb_to_rgbw_converter (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire rgbw_pkg::pixel_in_t  pixel,
    output logic                      done,
    output rgbw_pkg::pixel_out_t      rgbw,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [3:0]           cfg_data
);

    logic [3:0]          mode_reg;
    logic                accept;
    rgbw_pkg::scaled_t   scaled_word;
    rgbw_pkg::white_t    white_word;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= rgbw_pkg::MODE_OFF;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    rgbw_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .mode        (mode_reg),
        .pixel       (pixel),
        .scaled_word (scaled_word)
    );

    rgbw_white u_white (
        .clk         (clk),
        .rst_n       (rst_n),
        .scaled_word (scaled_word),
        .white_word  (white_word)
    );

    rgbw_extract u_extract (
        .clk        (clk),
        .rst_n      (rst_n),
        .white_word (white_word),
        .done       (done),
        .rgbw       (rgbw)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/rgbw_scale.sv
// First two pipeline stages: per-lane weight multiply, then scaled channel value.
// Depends on rgbw_pkg.
`default_nettype none

module rgbw_scale (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [3:0]          mode,
    input  wire rgbw_pkg::pixel_in_t pixel,
    output rgbw_pkg::scaled_t        scaled_word
);

    rgbw_pkg::chan3_t                     ch_in;
    logic                                 a_valid_reg;
    logic [3:0]                           a_mode_reg;
    rgbw_pkg::chan3_t                     a_ch_reg;
    logic [2:0][rgbw_pkg::PROD_W-1:0]     a_prod_reg;
    logic [2:0][rgbw_pkg::PROD_W-1:0]     a_prod_next;
    logic                                 b_valid_reg;
    logic [3:0]                           b_mode_reg;
    rgbw_pkg::chan3_t                     b_ch_reg;
    rgbw_pkg::scl3_t                      b_scl_reg;
    rgbw_pkg::scl3_t                      b_scl_next;

    assign ch_in = {pixel.blue_in, pixel.green_in, pixel.red_in};

    // Lane multipliers: channel times mode weight
    for (genvar i = 0; i < 3; i++) begin : g_mul
        assign a_prod_next[i] = {{rgbw_pkg::COEF_W{1'b0}}, ch_in[i]}
                              * {8'd0, rgbw_pkg::fwd_coef(mode, 2'(i))};
    end

    // Scaled value per lane
    for (genvar i = 0; i < 3; i++) begin : g_scl
        always_comb
        begin
            case (a_mode_reg) inside
                rgbw_pkg::MODE_WARM,
                rgbw_pkg::MODE_COOL:
                    b_scl_next[i] = a_prod_reg[i][rgbw_pkg::PROD_W-1:rgbw_pkg::FRAC_BITS];
                rgbw_pkg::MODE_COLD,
                rgbw_pkg::MODE_NEUTRAL:
                    b_scl_next[i] = {{(rgbw_pkg::SCL_W-8){1'b0}},
                                     rgbw_pkg::rdiv255(a_prod_reg[i][15:0])};
                default:
                    b_scl_next[i] = {{(rgbw_pkg::SCL_W-8){1'b0}}, a_ch_reg[i]};
            endcase
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        a_mode_reg <= mode;
        a_ch_reg   <= ch_in;
        a_prod_reg <= a_prod_next;
        b_mode_reg <= a_mode_reg;
        b_ch_reg   <= a_ch_reg;
        b_scl_reg  <= b_scl_next;
    end

    assign scaled_word.valid = b_valid_reg;
    assign scaled_word.mode  = b_mode_reg;
    assign scaled_word.ch    = b_ch_reg;
    assign scaled_word.scl   = b_scl_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rgbw_white.sv
// Third pipeline stage: picks the white drive as minimum or maximum of the lanes, or zero.
// Depends on rgbw_pkg.
`default_nettype none

module rgbw_white (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rgbw_pkg::scaled_t scaled_word,
    output rgbw_pkg::white_t       white_word
);

    logic [rgbw_pkg::SCL_W-1:0] lo01;
    logic [rgbw_pkg::SCL_W-1:0] lo;
    logic [rgbw_pkg::SCL_W-1:0] hi01;
    logic [rgbw_pkg::SCL_W-1:0] hi;
    logic [rgbw_pkg::SCL_W-1:0] pick;
    logic [7:0]                 white_next;
    logic                       valid_reg;
    logic [3:0]                 mode_reg;
    rgbw_pkg::chan3_t           ch_reg;
    rgbw_pkg::scl3_t            scl_reg;
    logic [7:0]                 white_reg;

    // Min and max of the three lanes
    assign lo01 = (scaled_word.scl[0] < scaled_word.scl[1]) ? scaled_word.scl[0]
                                                            : scaled_word.scl[1];
    assign lo   = (lo01 < scaled_word.scl[2]) ? lo01 : scaled_word.scl[2];
    assign hi01 = (scaled_word.scl[0] > scaled_word.scl[1]) ? scaled_word.scl[0]
                                                            : scaled_word.scl[1];
    assign hi   = (hi01 > scaled_word.scl[2]) ? hi01 : scaled_word.scl[2];

    // White select and clamp
    always_comb
    begin
        pick = (scaled_word.mode == rgbw_pkg::MODE_AUTOMAX) ? hi : lo;
        case (scaled_word.mode) inside
            rgbw_pkg::MODE_SUBMIN, rgbw_pkg::MODE_AUTOACC, rgbw_pkg::MODE_WARM,
            rgbw_pkg::MODE_COOL, rgbw_pkg::MODE_AUTO, rgbw_pkg::MODE_AUTOMAX,
            rgbw_pkg::MODE_COLD, rgbw_pkg::MODE_NEUTRAL:
                white_next = (pick > rgbw_pkg::SCL_W'(255)) ? 8'hFF : pick[7:0];
            default:
                white_next = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= scaled_word.valid;
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= scaled_word.mode;
        ch_reg    <= scaled_word.ch;
        scl_reg   <= scaled_word.scl;
        white_reg <= white_next;
    end

    assign white_word.valid = valid_reg;
    assign white_word.mode  = mode_reg;
    assign white_word.ch    = ch_reg;
    assign white_word.scl   = scl_reg;
    assign white_word.white = white_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rgbw_extract.sv
// Last two pipeline stages: amount to remove per lane, then saturating subtract.
// Depends on rgbw_pkg.
`default_nettype none

module rgbw_extract (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rgbw_pkg::white_t   white_word,
    output logic                    done,
    output rgbw_pkg::pixel_out_t    rgbw
);

    rgbw_pkg::sub3_t                    d_sub_next;
    logic [2:0][rgbw_pkg::IPROD_W-1:0]  iprod;
    logic                               d_valid_reg;
    rgbw_pkg::chan3_t                   d_ch_reg;
    rgbw_pkg::sub3_t                    d_sub_reg;
    logic [7:0]                         d_white_reg;
    rgbw_pkg::chan3_t                   e_out_next;
    logic                               e_valid_reg;
    rgbw_pkg::chan3_t                   e_out_reg;
    logic [7:0]                         e_white_reg;

    // Amount taken off each lane
    for (genvar i = 0; i < 3; i++) begin : g_sub
        assign iprod[i] = {{rgbw_pkg::INV_W{1'b0}}, white_word.white}
                        * {8'd0, rgbw_pkg::inv_coef(white_word.mode, 2'(i))};

        always_comb
        begin
            case (white_word.mode) inside
                rgbw_pkg::MODE_WARM, rgbw_pkg::MODE_COOL:
                    d_sub_next[i] = iprod[i][rgbw_pkg::IPROD_W-1:rgbw_pkg::FRAC_BITS];
                rgbw_pkg::MODE_SUBMIN, rgbw_pkg::MODE_AUTOACC:
                    d_sub_next[i] = {{(rgbw_pkg::SUB_W-8){1'b0}}, white_word.white};
                rgbw_pkg::MODE_COLD, rgbw_pkg::MODE_NEUTRAL:
                    d_sub_next[i] = {{(rgbw_pkg::SUB_W-8){1'b0}}, white_word.scl[i][7:0]};
                default:
                    d_sub_next[i] = '0;
            endcase
        end

        // Saturating subtract
        assign e_out_next[i] = (d_sub_reg[i] > {{(rgbw_pkg::SUB_W-8){1'b0}}, d_ch_reg[i]})
                             ? 8'd0
                             : d_ch_reg[i] - d_sub_reg[i][7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= white_word.valid;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_ch_reg    <= white_word.ch;
        d_sub_reg   <= d_sub_next;
        d_white_reg <= white_word.white;
        e_out_reg   <= e_out_next;
        e_white_reg <= d_white_reg;
    end

    assign done            = e_valid_reg;
    assign rgbw.red_out    = e_out_reg[0];
    assign rgbw.green_out  = e_out_reg[1];
    assign rgbw.blue_out   = e_out_reg[2];
    assign rgbw.white_out  = e_white_reg;

endmodule

`default_nettype wire

FILE: tb/sv/rgb_to_rgbw_converter_test.sv
// Self-checking testbench for rgb_to_rgbw_converter: directed table, then random pixels
// over every mode, each result word checked against a typed-in word or a white extraction predictor.
// Depends on rgbw_pkg (word types, mode codes) and the rgb_to_rgbw_converter RTL.
`timescale 1ns / 100ps

module rgb_to_rgbw_converter_test;

    // First and last undefined mode codes, which select no extraction
    localparam logic [3:0] MODE_UNDEF_LO = 4'd9;
    localparam logic [3:0] MODE_UNDEF_HI = 4'd15;

    localparam int ROW_COUNT       = 26;
    localparam int PHASE_COUNT     = 16;
    localparam int ITEMS_PER_PHASE = 53;

    // Fixed-point weights and inverses, 16 fraction bits, lane 0 = red
    localparam logic [2:0][19:0] WARM_FWD = {20'd152895, 20'd29753, 20'd17957};
    localparam logic [2:0][19:0] WARM_INV = {20'd28091, 20'd144352, 20'd239182};
    localparam logic [2:0][19:0] COOL_FWD = {20'd7471, 20'd38470, 20'd19595};
    localparam logic [2:0][19:0] COOL_INV = {20'd574877, 20'd111646, 20'd219184};
    // Scale gains for the cold and neutral modes
    localparam logic [2:0][19:0] COLD_GAIN = {20'h000A0, 20'h000A0, 20'h000A0};
    localparam logic [2:0][19:0] NEUT_GAIN = {20'h00070, 20'h000B0, 20'h000B0};

    typedef struct {
        logic [3:0]           mode;
        rgbw_pkg::pixel_in_t  px;
        bit                   fixed;   // want is typed in, else predicted
        rgbw_pkg::pixel_out_t want;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    rgbw_pkg::pixel_in_t  pixel;
    logic                 done;
    rgbw_pkg::pixel_out_t rgbw;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [3:0]           cfg_data;

    rgbw_pkg::pixel_out_t rgbw_due[$];
    logic [3:0]           cur_mode;
    int                   errors;

    // Directed words: extremes, every mode, undefined codes
    row_t directed_rows [0:ROW_COUNT-1] = '{
        '{rgbw_pkg::MODE_OFF,      24'h000000, 1'b1, 32'h00000000},
        '{rgbw_pkg::MODE_OFF,      24'hFFFFFF, 1'b1, 32'hFFFFFF00},
        '{rgbw_pkg::MODE_OFF,      24'hFF0080, 1'b1, 32'hFF008000},
        '{rgbw_pkg::MODE_SUBMIN,   24'hFFFFFF, 1'b1, 32'h000000FF},
        '{rgbw_pkg::MODE_SUBMIN,   24'hFF40C0, 1'b1, 32'hBF008040},
        '{rgbw_pkg::MODE_SUBMIN,   24'h00FFFF, 1'b1, 32'h00FFFF00},
        '{rgbw_pkg::MODE_WARM,     24'hFFFFFF, 1'b0, 32'h0},
        '{rgbw_pkg::MODE_WARM,     24'h00FFFF, 1'b1, 32'h00FFFF00},
        '{rgbw_pkg::MODE_WARM,     24'h010101, 1'b0, 32'h0},
        '{rgbw_pkg::MODE_WARM,     24'h806020, 1'b0, 32'h0},
        '{rgbw_pkg::MODE_COOL,     24'hFFFFFF, 1'b0, 32'h0},
        '{rgbw_pkg::MODE_COOL,     24'hFFFF00, 1'b1, 32'hFFFF0000},
        '{rgbw_pkg::MODE_COOL,     24'h4020FF, 1'b0, 32'h0},
        '{rgbw_pkg::MODE_AUTO,     24'hFF1080, 1'b1, 32'hFF108010},
        '{rgbw_pkg::MODE_AUTO,     24'h000000, 1'b1, 32'h00000000},
        '{rgbw_pkg::MODE_AUTOMAX,  24'hFF1080, 1'b1, 32'hFF1080FF},
        '{rgbw_pkg::MODE_AUTOMAX,  24'h010000, 1'b1, 32'h01000001},
        '{rgbw_pkg::MODE_AUTOACC,  24'hFFFFFF, 1'b1, 32'h000000FF},
        '{rgbw_pkg::MODE_AUTOACC,  24'h203010, 1'b1, 32'h10200010},
        '{rgbw_pkg::MODE_COLD,     24'hFFFFFF, 1'b1, 32'h5F5F5FA0},
        '{rgbw_pkg::MODE_COLD,     24'h000000, 1'b1, 32'h00000000},
        '{rgbw_pkg::MODE_COLD,     24'h80FF10, 1'b0, 32'h0},
        '{rgbw_pkg::MODE_NEUTRAL,  24'hFFFFFF, 1'b1, 32'h4F4F8F70},
        '{rgbw_pkg::MODE_NEUTRAL,  24'h37C591, 1'b0, 32'h0},
        '{MODE_UNDEF_LO,           24'hFF8001, 1'b1, 32'hFF800100},
        '{MODE_UNDEF_HI,           24'hFF8001, 1'b1, 32'hFF800100}
    };

    rgb_to_rgbw_converter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .rgbw      (rgbw),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned least3(input int unsigned a, b, c);
        int unsigned m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    // Rounded divide by 255, saturating at 255
    function automatic int unsigned div255_round(input int unsigned x);
        int unsigned q;
        q = (x + 127) / 255;
        return (q > 255) ? 255 : q;
    endfunction

    // Expected RGBW word for one pixel under the given mode
    function automatic rgbw_pkg::pixel_out_t predict_rgbw(input logic [3:0] mode,
                                                          input rgbw_pkg::pixel_in_t px);
        int unsigned          ch [3];
        int unsigned          o [3];
        int unsigned          s [3];
        int unsigned          wh;
        int unsigned          cut;
        logic [2:0][19:0]     fwd;
        logic [2:0][19:0]     inv;
        rgbw_pkg::pixel_out_t r;
        ch[0] = px.red_in;
        ch[1] = px.green_in;
        ch[2] = px.blue_in;
        for (int i = 0; i < 3; i++)
            o[i] = ch[i];
        wh = 0;
        case (mode) inside
            rgbw_pkg::MODE_SUBMIN, rgbw_pkg::MODE_AUTOACC:
            begin
                wh = least3(ch[0], ch[1], ch[2]);
                for (int i = 0; i < 3; i++)
                    o[i] = ch[i] - wh;
            end
            rgbw_pkg::MODE_WARM, rgbw_pkg::MODE_COOL:
            begin
                fwd = (mode == rgbw_pkg::MODE_WARM) ? WARM_FWD : COOL_FWD;
                inv = (mode == rgbw_pkg::MODE_WARM) ? WARM_INV : COOL_INV;
                for (int i = 0; i < 3; i++)
                    s[i] = (ch[i] * int'(fwd[i])) >> 16;
                wh = least3(s[0], s[1], s[2]);
                if (wh > 255)
                    wh = 255;
                // rounding in the inverse can overshoot: clamp at zero
                for (int i = 0; i < 3; i++)
                begin
                    cut = (wh * int'(inv[i])) >> 16;
                    o[i] = (cut > ch[i]) ? 0 : ch[i] - cut;
                end
            end
            rgbw_pkg::MODE_AUTO:
                wh = least3(ch[0], ch[1], ch[2]);
            rgbw_pkg::MODE_AUTOMAX:
            begin
                wh = (ch[0] > ch[1]) ? ch[0] : ch[1];
                wh = (wh > ch[2]) ? wh : ch[2];
            end
            rgbw_pkg::MODE_COLD, rgbw_pkg::MODE_NEUTRAL:
            begin
                fwd = (mode == rgbw_pkg::MODE_COLD) ? COLD_GAIN : NEUT_GAIN;
                for (int i = 0; i < 3; i++)
                begin
                    s[i] = div255_round(int'(fwd[i]) * ch[i]);
                    o[i] = ch[i] - s[i];
                end
                wh = div255_round(255 * least3(s[0], s[1], s[2]));
            end
            default:
                wh = 0;
        endcase
        r.red_out   = o[0][7:0];
        r.green_out = o[1][7:0];
        r.blue_out  = o[2][7:0];
        r.white_out = wh[7:0];
        return r;
    endfunction

    // Random pixel: gray, saturated corners, near-zero or fully random
    function automatic rgbw_pkg::pixel_in_t random_pixel();
        rgbw_pkg::pixel_in_t px;
        logic [7:0]          v;
        v = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: px = {v, v, v};
            1: px = {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
            2: px = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                     8'($urandom_range(0, 3))};
            default: px = 24'($urandom);
        endcase
        return px;
    endfunction

    // Present one word and hold it until taken
    task automatic send_pixel(input rgbw_pkg::pixel_in_t px,
                              input rgbw_pkg::pixel_out_t want);
        start <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rgbw_due.push_back(want);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Hold off the sender until every result word is back
    task automatic drain_results();
        start <= 1'b0;
        while (rgbw_due.size() != 0)
            @(posedge clk);
    endtask

    // Mode register write, only with the pipeline empty
    task automatic set_mode(input logic [3:0] m);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result checker: every strobe pops the oldest expected word
    always @(posedge clk)
    begin : watch_results
        rgbw_pkg::pixel_out_t want;
        if (rst_n && done)
        begin
            if (rgbw_due.size() == 0)
            begin
                $display("%0t: result word %h with none expected", $time, rgbw);
                errors++;
            end
            else
            begin
                want = rgbw_due.pop_front();
                check_field("red_out", want.red_out, rgbw.red_out);
                check_field("green_out", want.green_out, rgbw.green_out);
                check_field("blue_out", want.blue_out, rgbw.blue_out);
                check_field("white_out", want.white_out, rgbw.white_out);
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        rgbw_pkg::pixel_in_t px;
        int                  count;
        int                  burst;
        bit                  steady;
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        pixel     = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        cur_mode  = rgbw_pkg::MODE_OFF;
        errors    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, first rows run on the reset mode
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            if (directed_rows[i].mode != cur_mode)
                set_mode(directed_rows[i].mode);
            send_pixel(directed_rows[i].px, directed_rows[i].fixed ? directed_rows[i].want
                       : predict_rgbw(cur_mode, directed_rows[i].px));
            pause_sender($urandom_range(0, 2));
        end

        // random phases, one per mode code, in scrambled order
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_mode(4'((p * 7 + 8) % 16));
            count  = 0;
            steady = ($urandom_range(0, 3) == 0);
            while (count < ITEMS_PER_PHASE)
            begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && count < ITEMS_PER_PHASE; k++)
                begin
                    px = random_pixel();
                    send_pixel(px, predict_rgbw(cur_mode, px));
                    count++;
                    if (p == 5 && count == 20)
                        drain_results();
                end
                if (!steady)
                    pause_sender($urandom_range(0, 6));
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0 && rgbw_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: rgb_to_rgbw_converter.f
hw/rtl/rgbw_pkg.sv
hw/rtl/rgbw_scale.sv
hw/rtl/rgbw_white.sv
hw/rtl/rgbw_extract.sv
hw/rtl/rgb_to_rgbw_converter.sv
tb/sv/rgb_to_rgbw_converter_test.sv
